[sv/multi_axis_step_generator_unit_assert.svh]
// assertion helpers used by the step generator engine module
// both expect clk and rst_n in scope
`ifndef MULTI_AXIS_STEP_GENERATOR_UNIT_ASSERT_SVH
`define MULTI_AXIS_STEP_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define MSG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/msg_pkg.sv]
// ----------------------------------------------------------------------------
// msg_pkg
// shared types and constants of the multi-axis step generator
// ----------------------------------------------------------------------------
package msg_pkg;

    localparam int NUM_AXES_MAX = 4;

    localparam logic [31:0] PERIOD_NUM = 32'd250000;
    localparam logic [15:0] RATE_FLOOR = 16'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_STEP_INVERT = 2'd0;
    localparam logic [1:0] CFG_INV_ACCEL   = 2'd1;
    localparam logic [1:0] CFG_MIN_RATE    = 2'd2;
    localparam logic [1:0] CFG_AUTO_EN     = 2'd3;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        PH_NONE   = 2'd0,
        PH_ACC    = 2'd1,
        PH_DEC    = 2'd2,
        PH_CRUISE = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        E_IDLE,
        E_LOAD,
        E_STEP,
        E_RATE,
        E_QDIV,
        E_PDIV,
        E_FIN,
        E_OUT
    } eng_state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] seg_time;
        logic [14:0] seg_steps;
        logic [14:0] seg_decel_steps;
        logic [15:0] seg_rate;
        logic [3:0]  seg_dirs;
        logic [15:0] axis0_count;
        logic [15:0] axis1_count;
        logic [15:0] axis2_count;
        logic [15:0] axis3_count;
    } item_t;

    typedef struct packed {
        logic [3:0]  step_out;
        logic [3:0]  dir_out;
        logic [15:0] timer_period;
        logic        running;
        logic        push_dropped;
        logic [31:0] pos_axis0;
        logic [31:0] pos_axis1;
        logic [31:0] pos_axis2;
        logic [31:0] pos_axis3;
    } result_t;

    // one queued motion segment
    typedef struct packed {
        logic [15:0]                   seg_time;
        logic [14:0]                   steps;
        logic [14:0]                   decel;
        logic [15:0]                   rate;
        logic [3:0]                    dirs;
        logic [NUM_AXES_MAX-1:0][15:0] counts;
    } seg_t;

    // classified command from the front end
    typedef struct packed {
        cmd_e_t cmd;
        seg_t   seg;
    } fe_item_t;

    typedef struct packed {
        logic     valid;
        fe_item_t item;
    } fe_out_t;

endpackage

[sv/msg_front.sv]
// ----------------------------------------------------------------------------
// msg_front
// input queue: accepts items, decodes the command and buffers them
// ----------------------------------------------------------------------------
module msg_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  msg_pkg::item_t   item,
    output msg_pkg::fe_out_t fe_out,
    input  logic             take
);
    import msg_pkg::*;

    fe_item_t   buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    fe_item_t   decoded;
    logic       wr_en, rd_en;

    always_comb
    begin
        decoded.cmd              = cmd_e_t'(item.mode);
        decoded.seg.seg_time     = item.seg_time;
        decoded.seg.steps        = item.seg_steps;
        decoded.seg.decel        = item.seg_decel_steps;
        decoded.seg.rate         = item.seg_rate;
        decoded.seg.dirs         = item.seg_dirs;
        decoded.seg.counts[0]    = item.axis0_count;
        decoded.seg.counts[1]    = item.axis1_count;
        decoded.seg.counts[2]    = item.axis2_count;
        decoded.seg.counts[3]    = item.axis3_count;
    end

    assign full         = (cnt_reg == 2'd2);
    assign wr_en        = push && !full;
    assign rd_en        = take && (cnt_reg != 2'd0);
    assign fe_out.valid = (cnt_reg != 2'd0);
    assign fe_out.item  = buf_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

[sv/msg_div.sv]
// ----------------------------------------------------------------------------
// msg_div
// iterative 32 by 16 bit unsigned divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
module msg_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    localparam int ITERS = 16;
    localparam int CW    = $clog2(ITERS);

    logic [15:0]   rem_reg, rem_next;
    logic [31:0]   dq_reg, dq_next;
    logic [15:0]   d_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [16:0]   sh;
    logic          ge;

    always_comb
    begin
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sh        = '0;
        ge        = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dq_next   = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 2; i++)
            begin
                sh       = {rem_next, dq_next[31]};
                ge       = (sh >= {1'b0, d_reg});
                sh       = ge ? (sh - {1'b0, d_reg}) : sh;
                rem_next = sh[15:0];
                dq_next  = {dq_next[30:0], ge};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(ITERS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

[sv/msg_engine.sv]
// ----------------------------------------------------------------------------
// msg_engine
// back end: segment ring, bresenham lanes, rate ramp and result register
// ----------------------------------------------------------------------------
module msg_engine #(
    parameter int QUEUE_DEPTH = 16,
    parameter int AXES        = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  msg_pkg::fe_out_t fe_out,
    output logic             take,
    output logic             empty,
    input  logic             pop,
    output msg_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);
    import msg_pkg::*;

    `include "multi_axis_step_generator_unit_assert.svh"

    localparam int QW = $clog2(QUEUE_DEPTH);

    function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
        logic [QW-1:0] r;
        r = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    // configuration
    logic [3:0]  mask_reg;
    logic [15:0] inv_reg;
    logic [15:0] min_rate_reg;
    logic        auto_reg;

    // segment ring
    seg_t          seg_mem [QUEUE_DEPTH];
    seg_t          rd_data_reg;
    logic [QW-1:0] head_reg, head_next;
    logic [QW-1:0] tail_reg, tail_next;
    logic [QW-1:0] head_inc, tail_inc;
    logic          mem_we;

    eng_state_t  state_reg, state_next;
    logic        active_reg, active_next;
    seg_t        seg_reg, seg_next;
    logic [15:0] remain_reg, remain_next;
    logic [17:0] err_reg [NUM_AXES_MAX];
    logic [17:0] err_next [NUM_AXES_MAX];
    logic [31:0] pos_reg [NUM_AXES_MAX];
    logic [31:0] pos_next [NUM_AXES_MAX];
    logic [15:0] rate_reg, rate_next;
    logic [15:0] start_rate_reg, start_rate_next;
    logic [31:0] ramp_time_reg, ramp_time_next;
    logic [15:0] period_reg, period_next;
    phase_t      phase_reg, phase_next;
    logic [3:0]  pending_reg, pending_next;
    logic [3:0]  step_port_reg, step_port_next;
    logic [3:0]  dir_reg, dir_next;
    logic        running_reg, running_next;
    logic        is_start_reg, is_start_next;
    logic        is_dec_reg, is_dec_next;
    logic        dropped_reg, dropped_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;

    // bresenham lanes
    logic [17:0] lane_sum [NUM_AXES_MAX];
    logic [17:0] lane_err [NUM_AXES_MAX];
    logic [31:0] lane_pos [NUM_AXES_MAX];
    logic [3:0]  lane_pat;

    // divider
    logic        div_start;
    logic [31:0] div_dividend;
    logic [15:0] div_divisor;
    logic        div_done;
    logic [31:0] div_q;

    // ramp arithmetic
    logic [15:0] inv_eff;
    logic [15:0] q_sat;
    logic [16:0] acc_sum;
    logic [15:0] ramp_rate;
    logic [31:0] rt_base;
    logic        dec_cond, acc_cond;

    assign head_inc  = ptr_inc(head_reg);
    assign tail_inc  = ptr_inc(tail_reg);
    assign cfg_ready = 1'b1;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;
    assign take      = (state_reg == E_IDLE) && fe_out.valid;
    assign inv_eff   = (inv_reg == 16'd0) ? 16'd1 : inv_reg;

    msg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // per-axis error accumulate, compare and position move
    always_comb
    begin
        lane_pat = '0;
        for (int a = 0; a < NUM_AXES_MAX; a++)
        begin
            lane_sum[a] = err_reg[a] + {2'b00, seg_reg.counts[a]};
            lane_err[a] = err_reg[a];
            lane_pos[a] = pos_reg[a];
            if ((a < AXES) &&
                ($signed({lane_sum[a], 1'b0}) >= $signed({3'b000, seg_reg.seg_time})))
            begin
                lane_err[a] = lane_sum[a] - {2'b00, seg_reg.seg_time};
                lane_pat[a] = 1'b1;
                lane_pos[a] = seg_reg.dirs[a] ? pos_reg[a] - 32'd1 : pos_reg[a] + 32'd1;
            end
            else if (a < AXES)
            begin
                lane_err[a] = lane_sum[a];
            end
        end
    end

    // ramp rate from the quotient of ramp time over inverse acceleration
    always_comb
    begin
        q_sat   = (div_q[31:16] != 16'd0) ? 16'hFFFF : div_q[15:0];
        acc_sum = {1'b0, start_rate_reg} + {1'b0, q_sat};
        if (is_dec_reg)
        begin
            ramp_rate = ({2'b00, start_rate_reg} >= ({2'b00, q_sat} + {2'b00, RATE_FLOOR}))
                        ? start_rate_reg - q_sat : RATE_FLOOR;
        end
        else
        begin
            ramp_rate = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
        end
        dec_cond = (remain_reg < {1'b0, seg_reg.decel});
        acc_cond = (rate_reg < seg_reg.rate);
        rt_base  = '0;
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        mem_we          = 1'b0;
        active_next     = active_reg;
        seg_next        = seg_reg;
        remain_next     = remain_reg;
        err_next        = err_reg;
        pos_next        = pos_reg;
        rate_next       = rate_reg;
        start_rate_next = start_rate_reg;
        ramp_time_next  = ramp_time_reg;
        period_next     = period_reg;
        phase_next      = phase_reg;
        pending_next    = pending_reg;
        step_port_next  = step_port_reg;
        dir_next        = dir_reg;
        running_next    = running_reg;
        is_start_next   = is_start_reg;
        is_dec_next     = is_dec_reg;
        dropped_next    = dropped_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_next        = out_reg;
        div_start       = 1'b0;
        div_dividend    = '0;
        div_divisor     = RATE_FLOOR;

        unique case (state_reg)
            E_IDLE:
            begin
                if (fe_out.valid)
                begin
                    dropped_next = 1'b0;
                    state_next   = E_OUT;
                    case (fe_out.item.cmd)
                        CMD_PUSH:
                        begin
                            if (head_inc != tail_reg)
                            begin
                                mem_we    = 1'b1;
                                head_next = head_inc;
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        CMD_START:
                        begin
                            if (auto_reg)
                            begin
                                rate_next     = (min_rate_reg < RATE_FLOOR) ? RATE_FLOOR
                                                                            : min_rate_reg;
                                is_start_next = 1'b1;
                                state_next    = E_LOAD;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (auto_reg && running_reg)
                            begin
                                step_port_next = pending_reg;
                                is_start_next  = 1'b0;
                                state_next     = E_LOAD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            E_LOAD:
            begin
                if (!active_reg && (head_reg != tail_reg))
                begin
                    tail_next   = tail_inc;
                    seg_next    = rd_data_reg;
                    remain_next = {1'b0, rd_data_reg.steps};
                    dir_next    = rd_data_reg.dirs;
                    for (int a = 0; a < NUM_AXES_MAX; a++)
                    begin
                        err_next[a] = '0;
                    end
                    active_next = 1'b1;
                    state_next  = E_STEP;
                end
                else if (active_reg)
                begin
                    state_next = E_STEP;
                end
                else
                begin
                    if (!is_start_reg)
                    begin
                        running_next = 1'b0;
                        rate_next    = '0;
                        phase_next   = PH_NONE;
                    end
                    state_next = E_OUT;
                end
            end
            E_STEP:
            begin
                err_next     = lane_err;
                pos_next     = lane_pos;
                pending_next = lane_pat ^ mask_reg;
                remain_next  = remain_reg - 16'd1;
                if (remain_reg == 16'd1)
                begin
                    active_next = 1'b0;
                end
                state_next = E_RATE;
            end
            E_RATE:
            begin
                div_divisor = inv_eff;
                if (dec_cond || acc_cond)
                begin
                    is_dec_next = dec_cond;
                    if (phase_reg != (dec_cond ? PH_DEC : PH_ACC))
                    begin
                        start_rate_next = rate_reg;
                        div_dividend    = rt_base + {16'd0, period_reg};
                    end
                    else
                    begin
                        div_dividend = ramp_time_reg + {16'd0, period_reg};
                    end
                    phase_next     = dec_cond ? PH_DEC : PH_ACC;
                    ramp_time_next = div_dividend;
                    div_start      = 1'b1;
                    state_next     = E_QDIV;
                end
                else if (phase_reg != PH_CRUISE)
                begin
                    phase_next   = PH_CRUISE;
                    div_dividend = PERIOD_NUM;
                    div_divisor  = (rate_reg < RATE_FLOOR) ? RATE_FLOOR : rate_reg;
                    div_start    = 1'b1;
                    state_next   = E_PDIV;
                end
                else
                begin
                    state_next = E_FIN;
                end
            end
            E_QDIV:
            begin
                if (div_done)
                begin
                    rate_next    = ramp_rate;
                    div_dividend = PERIOD_NUM;
                    div_divisor  = (ramp_rate < RATE_FLOOR) ? RATE_FLOOR : ramp_rate;
                    div_start    = 1'b1;
                    state_next   = E_PDIV;
                end
            end
            E_PDIV:
            begin
                if (div_done)
                begin
                    period_next = div_q[15:0];
                    state_next  = E_FIN;
                end
            end
            E_FIN:
            begin
                if (is_start_reg)
                begin
                    phase_next   = PH_NONE;
                    running_next = 1'b1;
                end
                state_next = E_OUT;
            end
            E_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next.step_out     = step_port_reg;
                    out_next.dir_out      = dir_reg;
                    out_next.timer_period = period_reg;
                    out_next.running      = running_reg;
                    out_next.push_dropped = dropped_reg;
                    out_next.pos_axis0    = pos_reg[0];
                    out_next.pos_axis1    = pos_reg[1];
                    out_next.pos_axis2    = pos_reg[2];
                    out_next.pos_axis3    = pos_reg[3];
                    out_valid_next        = 1'b1;
                    state_next            = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= 4'd0;
            inv_reg      <= 16'd100;
            min_rate_reg <= 16'd50;
            auto_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_STEP_INVERT: mask_reg     <= cfg_data[3:0];
                CFG_INV_ACCEL:   inv_reg      <= cfg_data;
                CFG_MIN_RATE:    min_rate_reg <= cfg_data;
                CFG_AUTO_EN:     auto_reg     <= cfg_data[0];
                default:         auto_reg     <= auto_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= E_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            active_reg     <= 1'b0;
            seg_reg        <= '0;
            remain_reg     <= '0;
            for (int a = 0; a < NUM_AXES_MAX; a++)
            begin
                err_reg[a] <= '0;
                pos_reg[a] <= '0;
            end
            rate_reg       <= '0;
            start_rate_reg <= '0;
            ramp_time_reg  <= '0;
            period_reg     <= '0;
            phase_reg      <= PH_NONE;
            pending_reg    <= '0;
            step_port_reg  <= '0;
            dir_reg        <= '0;
            running_reg    <= 1'b0;
            is_start_reg   <= 1'b0;
            is_dec_reg     <= 1'b0;
            dropped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            active_reg     <= active_next;
            seg_reg        <= seg_next;
            remain_reg     <= remain_next;
            err_reg        <= err_next;
            pos_reg        <= pos_next;
            rate_reg       <= rate_next;
            start_rate_reg <= start_rate_next;
            ramp_time_reg  <= ramp_time_next;
            period_reg     <= period_next;
            phase_reg      <= phase_next;
            pending_reg    <= pending_next;
            step_port_reg  <= step_port_next;
            dir_reg        <= dir_next;
            running_reg    <= running_next;
            is_start_reg   <= is_start_next;
            is_dec_reg     <= is_dec_next;
            dropped_reg    <= dropped_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seg_mem[head_inc] <= fe_out.item.seg;
        end
        rd_data_reg <= seg_mem[tail_inc];
    end

    `MSG_ASSERT_IMP(a_div_nonzero, div_start, div_divisor != 16'd0,
        "divider started with zero divisor")
    `MSG_ASSERT_NXT(a_push_not_empty, mem_we, head_reg != tail_reg,
        "ring empty right after a stored segment")
    `MSG_ASSERT_NXT(a_start_runs, (state_reg == E_FIN) && is_start_reg,
        running_reg && (phase_reg == PH_NONE), "start did not leave engine running")

endmodule

[sv/multi_axis_step_generator_unit.sv]
// order of work: push, idle and no-op commands pass from E_IDLE straight to E_OUT
// start or tick with an empty ring: E_LOAD, then E_OUT; cruise tick with no rate change:
// E_LOAD, E_STEP, E_RATE, E_FIN, E_OUT; ramp tick or start: two divider passes, E_QDIV
// for ramp quotient and E_PDIV for 250000/rate period; a cruise entry needs one pass
// one item is worked on at a time; a 2-entry input queue takes items meanwhile
// reset: async active low; ring empty, engine stopped, positions and rate zero
// ----------------------------------------------------------------------------
// multi_axis_step_generator_unit
// four-axis bresenham step generator with trapezoidal rate ramp
// ----------------------------------------------------------------------------
module multi_axis_step_generator_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int AXES        = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    // input queue side
    input  logic             push,
    output logic             full,
    input  msg_pkg::item_t   item,
    // result queue side
    output logic             empty,
    input  logic             pop,
    output msg_pkg::result_t result,
    // configuration writes
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);
    import msg_pkg::*;

    // classified items waiting for the engine
    fe_out_t fe_out;
    // engine takes the head item on this transfer
    logic    take;

    // front: accepts and decodes commands
    msg_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .fe_out (fe_out),
        .take   (take)
    );

    // back: segment ring, step lanes, ramp control and result register
    msg_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AXES        (AXES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .fe_out    (fe_out),
        .take      (take),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
